// ----- design/bsa_pkg.sv -----
package bsa_pkg;

    // Bitmap word geometry
    localparam int unsigned WORD_BITS = 32;
    localparam int unsigned BIT_W     = 5;
    localparam int unsigned IDX_W     = 10;
    localparam int unsigned TDATA_W   = 16;

    // Command codes carried on s_tuser
    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    // Status codes carried on m_tuser
    typedef enum logic {
        STATUS_OK   = 1'b0,
        STATUS_FULL = 1'b1
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RMW
    } state_t;

    // Lowest clear bit of a word; 31 when every bit is set
    function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] b;
        b = BIT_W'(WORD_BITS - 1);
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!v[i])
            begin
                b = BIT_W'(i);
            end
        end
        return b;
    endfunction

endpackage

// ----- design/bitmap_slot_allocator_top.sv -----
// First-fit slot allocator over a used-slot bitmap of SLOTS bits, kept as
// 32-bit words in a synchronous RAM. An allocate transaction (s_tuser = 0)
// returns the lowest free slot and marks it used, or status full (m_tuser = 1)
// with index 0 when no slot is free; a free transaction (s_tuser = 1) clears
// the slot in s_tdata and returns index 0, status ok. Indexes at or beyond
// SLOTS are ignored on free. Only the low 10 bits of a granted index are
// returned. Each transaction reads the bitmap word in the idle state, then
// modifies it, writes it back and loads the result register in the
// write-back state; a per-word full vector in flip-flops picks the word to
// read. After reset the block clears every RAM word, with s_tready low,
// before taking its first transaction. A result waiting on m_tready stalls
// the next transaction only in its write-back state.
module bitmap_slot_allocator_top #(
    parameter int SLOTS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bsa_pkg::TDATA_W-1:0]   s_tdata,   // [9:0] slot_index, [15:10] zero
    input  logic                          s_tuser,   // [0] cmd
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bsa_pkg::TDATA_W-1:0]   m_tdata,   // [9:0] granted_index, [15:10] zero
    output logic                          m_tuser    // [0] status
);

    import bsa_pkg::*;

    localparam int MAP_DEPTH = (SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int LIVE_LAST = SLOTS - (MAP_DEPTH - 1) * WORD_BITS;
    localparam logic [WORD_BITS-1:0] PAD_LAST =
        (LIVE_LAST >= WORD_BITS) ? '0 : ({WORD_BITS{1'b1}} << LIVE_LAST);
    localparam logic [AW-1:0] LAST_WORD = AW'(MAP_DEPTH - 1);

    state_t state_reg, state_next;

    logic [AW-1:0]        clr_addr_reg, clr_addr_next;
    logic [MAP_DEPTH-1:0] full_reg, full_next;

    // Operation held between read and write-back
    cmd_t             op_cmd_reg, op_cmd_next;
    logic [AW-1:0]    op_addr_reg, op_addr_next;
    logic [BIT_W-1:0] op_bit_reg, op_bit_next;
    logic             op_ok_reg, op_ok_next;

    // Result register
    logic             out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] out_index_reg, out_index_next;
    status_t          out_status_reg, out_status_next;

    logic                 ram_wr_en, ram_rd_en;
    logic [AW-1:0]        ram_wr_addr;
    logic [WORD_BITS-1:0] ram_wr_data, ram_rd_data;

    logic                 accept, out_free, load;
    logic [AW-1:0]        first_word;
    logic                 all_full;
    logic [16:0]          idx_ext;
    logic [WORD_BITS-1:0] word_view, word_new;
    logic [BIT_W-1:0]     alloc_bit;
    logic [31:0]          granted_ext;

    bsa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (op_addr_next),
        .rd_data (ram_rd_data)
    );

    // Lowest word that still has a free slot
    always_comb
    begin
        first_word = '0;
        for (int i = MAP_DEPTH - 1; i >= 0; i--)
        begin
            if (!full_reg[i])
            begin
                first_word = AW'(i);
            end
        end
    end

    assign all_full = &full_reg;
    assign idx_ext  = {7'b0, s_tdata[IDX_W-1:0]};
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign load     = (state_reg == ST_RMW) && out_free;

    // Decode the incoming transaction
    always_comb
    begin
        if (cmd_t'(s_tuser) == CMD_FREE)
        begin
            op_cmd_next  = CMD_FREE;
            op_addr_next = idx_ext[BIT_W +: AW];
            op_bit_next  = idx_ext[BIT_W-1:0];
            op_ok_next   = (idx_ext < 17'(SLOTS));
        end
        else
        begin
            op_cmd_next  = CMD_ALLOC;
            op_addr_next = first_word;
            op_bit_next  = '0;
            op_ok_next   = !all_full;
        end
    end

    // Modify the word read back
    always_comb
    begin
        word_view = ram_rd_data | ((op_addr_reg == LAST_WORD) ? PAD_LAST : '0);
        alloc_bit = lowest_zero(word_view);
        if (op_cmd_reg == CMD_FREE)
        begin
            word_new = ram_rd_data & ~(WORD_BITS'(1) << op_bit_reg);
        end
        else
        begin
            word_new = ram_rd_data | (WORD_BITS'(1) << alloc_bit);
        end
        granted_ext = 32'({op_addr_reg, alloc_bit});
    end

    // Next state
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_WORD)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RMW;
                end
            end
            ST_RMW:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        s_tready    = 1'b0;
        ram_rd_en   = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = op_addr_reg;
        ram_wr_data = word_new;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_addr_reg;
                ram_wr_data = '0;
            end
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                ram_rd_en = s_tvalid;
            end
            ST_RMW:
            begin
                ram_wr_en = out_free && op_ok_reg;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Full vector tracks every write-back
    always_comb
    begin
        full_next = full_reg;
        if (load && op_ok_reg)
        begin
            full_next[op_addr_reg] =
                &(word_new | ((op_addr_reg == LAST_WORD) ? PAD_LAST : '0));
        end
    end

    // Result register
    always_comb
    begin
        out_valid_next  = out_valid_reg && !m_tready;
        out_index_next  = out_index_reg;
        out_status_next = out_status_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            if (op_cmd_reg == CMD_FREE)
            begin
                out_index_next  = '0;
                out_status_next = STATUS_OK;
            end
            else if (op_ok_reg)
            begin
                out_index_next  = granted_ext[IDX_W-1:0];
                out_status_next = STATUS_OK;
            end
            else
            begin
                out_index_next  = '0;
                out_status_next = STATUS_FULL;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            full_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_cmd_reg  <= op_cmd_next;
            op_addr_reg <= op_addr_next;
            op_bit_reg  <= op_bit_next;
            op_ok_reg   <= op_ok_next;
        end
        out_index_reg  <= out_index_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(TDATA_W - IDX_W)'(0), out_index_reg};
    assign m_tuser  = out_status_reg;

    // An accepted transaction always goes to write-back next
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_RMW))
        else $error("accepted transaction did not reach write-back");

    // Results appear only out of write-back
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_RMW))
        else $error("result raised outside write-back");

    // RAM is never read and written in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_wr_en && ram_rd_en))
        else $error("RAM read and write overlap");

    // A full status carries index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == STATUS_FULL)) |-> (m_tdata == '0))
        else $error("full status with nonzero index");

    // No transaction is taken during the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("ready during clearing pass");

endmodule

// ----- design/bsa_ram.sv -----
module bsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import bsa_pkg::*;

    localparam int SLOT_COUNT  = 1024;
    localparam int MAP_WORDS   = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 100;

    // Shadow copy of the used-slot bitmap plus the grants it predicts
    class slot_map_checker;
        bit [WORD_BITS-1:0] used_words [MAP_WORDS];
        logic [IDX_W-1:0]   pending_grants [$];
        status_t            pending_status [$];
        int errors    = 0;
        int n_alloc   = 0;
        int n_free    = 0;
        int n_full    = 0;
        int n_checked = 0;

        // Slots past the end of the map count as taken
        function bit [WORD_BITS-1:0] word_view(int w);
            bit [WORD_BITS-1:0] ones;
            int live;
            ones = '1;
            live = SLOT_COUNT - w * WORD_BITS;
            if (live < WORD_BITS)
            begin
                return used_words[w] | (ones << live);
            end
            return used_words[w];
        endfunction

        function int first_clear_bit(bit [WORD_BITS-1:0] v);
            int b;
            b = 0;
            while (b < WORD_BITS - 1 && v[b])
            begin
                b++;
            end
            return b;
        endfunction

        function bit map_full();
            bit all_set;
            all_set = 1'b1;
            for (int w = 0; w < MAP_WORDS; w++)
            begin
                if (~word_view(w) != '0)
                begin
                    all_set = 1'b0;
                end
            end
            return all_set;
        endfunction

        function int pending();
            return pending_grants.size();
        endfunction

        // Update the map for one accepted transaction and queue its result
        function void note_request(cmd_t cmd, logic [IDX_W-1:0] idx);
            logic [IDX_W-1:0] grant;
            status_t st;
            int b;
            grant = '0;
            st = STATUS_OK;
            if (cmd == CMD_ALLOC)
            begin
                n_alloc++;
                st = STATUS_FULL;
                for (int w = 0; w < MAP_WORDS; w++)
                begin
                    if (st == STATUS_FULL && ~word_view(w) != '0)
                    begin
                        b = first_clear_bit(word_view(w));
                        used_words[w][b] = 1'b1;
                        grant = IDX_W'(w * WORD_BITS + b);
                        st = STATUS_OK;
                    end
                end
                if (st == STATUS_FULL)
                begin
                    n_full++;
                end
            end
            else
            begin
                n_free++;
                if (idx < SLOT_COUNT)
                begin
                    used_words[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
                end
            end
            pending_grants.push_back(grant);
            pending_status.push_back(st);
        endfunction

        // Compare one result transaction with the oldest prediction
        function void check_result(logic [TDATA_W-1:0] data, logic user);
            logic [IDX_W-1:0] exp_grant;
            status_t exp_st;
            if (pending_grants.size() == 0)
            begin
                $display("%0t: unexpected result: index %0d status %0d",
                         $time, data[IDX_W-1:0], user);
                errors++;
                return;
            end
            exp_grant = pending_grants.pop_front();
            exp_st = pending_status.pop_front();
            n_checked++;
            if (data[IDX_W-1:0] !== exp_grant)
            begin
                $display("%0t: granted_index mismatch: expected %0d actual %0d",
                         $time, exp_grant, data[IDX_W-1:0]);
                errors++;
            end
            if (user !== exp_st)
            begin
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, exp_st, user);
                errors++;
            end
            if (data[TDATA_W-1:IDX_W] !== '0)
            begin
                $display("%0t: tdata padding mismatch: expected 0 actual %0h",
                         $time, data[TDATA_W-1:IDX_W]);
                errors++;
            end
        endfunction
    endclass

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic [TDATA_W-1:0] s_tdata  = '0;
    logic               s_tuser  = CMD_ALLOC;
    logic               m_tready = 1'b0;
    logic               s_tready;
    logic               m_tvalid;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tuser;

    slot_map_checker slot_map;
    int cycles   = 0;
    bit quiet    = 1'b0;
    bit hold_req = 1'b0;
    bit holding  = 1'b0;

    always #5 clk = ~clk;

    bitmap_slot_allocator_top #(
        .SLOTS(SLOT_COUNT)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),   // [9:0] slot_index, [15:10] zero
        .s_tuser (s_tuser),   // [0] cmd
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),   // [9:0] granted_index, [15:10] zero
        .m_tuser (m_tuser)    // [0] status
    );

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            slot_map.check_result(m_tdata, m_tuser);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver: random ready stretches, stall bursts, one long hold-off on request
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                holding = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                holding = 1'b0;
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    // Offer one transaction and hold it until accepted
    task automatic offer(cmd_t cmd, logic [IDX_W-1:0] idx);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(TDATA_W - IDX_W){1'b0}}, idx};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        slot_map.note_request(cmd, idx);
    endtask

    task automatic pause(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Stop sending until every predicted result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (slot_map.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Random transaction; free_odds out of 16 are frees
    task automatic random_item(int free_odds);
        cmd_t cmd;
        logic [IDX_W-1:0] idx;
        int hi;
        hi = slot_map.n_alloc - slot_map.n_full;
        if (hi > SLOT_COUNT - 1)
        begin
            hi = SLOT_COUNT - 1;
        end
        idx = IDX_W'($urandom_range(0, SLOT_COUNT - 1));
        cmd = CMD_ALLOC;
        if ($urandom_range(0, 15) < free_odds)
        begin
            cmd = CMD_FREE;
            // half the frees aim at the region already handed out
            if ($urandom_range(0, 1) == 1)
            begin
                idx = IDX_W'($urandom_range(0, hi));
            end
        end
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            pause($urandom_range(1, 14));
        end
        offer(cmd, idx);
    endtask

    // Stimulus
    initial
    begin
        int k;
        slot_map = new;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: first grants, hole refill, double free, extreme indexes
        offer(CMD_ALLOC, '1);
        offer(CMD_ALLOC, '0);
        offer(CMD_ALLOC, 10'h2AA);
        offer(CMD_FREE, 10'd1);
        offer(CMD_ALLOC, 10'h155);
        offer(CMD_FREE, 10'd1023);
        offer(CMD_FREE, 10'd0);
        offer(CMD_FREE, 10'd0);
        offer(CMD_ALLOC, '0);
        offer(CMD_FREE, 10'h155);
        offer(CMD_FREE, 10'h2AA);
        repeat (6) offer(CMD_ALLOC, '0);
        offer(CMD_FREE, 10'd2);
        offer(CMD_FREE, 10'd5);
        offer(CMD_ALLOC, '1);
        offer(CMD_ALLOC, '1);
        drain();

        // Fill the map, mostly allocates with a few frees mixed in
        k = 0;
        while (!slot_map.map_full())
        begin
            if (k % 32 == 0)
            begin
                quiet = ($urandom_range(0, 3) == 0);
            end
            if (k == 300)
            begin
                // back-to-back traffic against a stalled receiver
                hold_req = 1'b1;
                pause(1);
                wait (holding);
                repeat (16) offer(CMD_ALLOC, IDX_W'($urandom_range(0, SLOT_COUNT - 1)));
            end
            random_item(1);
            k++;
        end
        drain();
        quiet = 1'b0;

        // Full map: allocates report full, freed slots are granted again
        repeat (3) offer(CMD_ALLOC, IDX_W'($urandom_range(0, SLOT_COUNT - 1)));
        offer(CMD_FREE, 10'd1023);
        offer(CMD_ALLOC, '0);
        offer(CMD_ALLOC, '0);
        offer(CMD_FREE, 10'd0);
        offer(CMD_FREE, 10'd512);
        offer(CMD_ALLOC, '1);
        offer(CMD_ALLOC, '1);
        offer(CMD_ALLOC, '1);

        // Churn near full
        repeat (80) random_item(8);
        drain();

        // Final stretch with no idling on either side
        quiet = 1'b1;
        repeat (60) random_item(8);
        drain();
        repeat (10) @(posedge clk);

        $display("run: %0d allocate and %0d free transactions, %0d answered full",
                 slot_map.n_alloc, slot_map.n_free, slot_map.n_full);
        $display("run: %0d results checked, %0d mismatches",
                 slot_map.n_checked, slot_map.errors);
        if (slot_map.errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- bitmap_slot_allocator_top.f -----
design/bsa_pkg.sv
design/bsa_ram.sv
design/bitmap_slot_allocator_top.sv
tb/testbench.sv
